// ----- src/sul_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sul_pkg
// shared constants and types for the sorted unique list: default depth,
// command codes, status codes and controller states
// ----------------------------------------------------------------------------
package sul_pkg;

	localparam int SUL_DEPTH = 16;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_PLACE
	} state_t;

endpackage : sul_pkg
`default_nettype wire

// ----- src/sul_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sul_ram
// simple dual port entry store: one write port, one read port with
// registered read data (the read data register sets the read latency)
// ----------------------------------------------------------------------------
module sul_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : sul_ram
`default_nettype wire

// ----- src/sorted_unique_list.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_list
// table of distinct signed values kept in ascending order; insert, search
// and remove commands, one result per command
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  command   start / busy     command, value
//  result    done (strobe)    status, position, entry_count
//
//  a command rejected at once (full, empty, code 3) answers in the next cycle;
//  otherwise the scan walks the entry store one entry a cycle, an insert or
//  remove then moves the entries from the insert point up, or above the match,
//  one a cycle through the single read and write port, and an insert adds a
//  place state; busy falls as the result strobe rises.
//  no clearing pass after reset; the result cannot be held off.
// ----------------------------------------------------------------------------
module sorted_unique_list
	import sul_pkg::*;
#(
	parameter int DEPTH = SUL_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [1:0]  command,
	input  wire logic signed [31:0] value,
	output logic                    done,
	output logic             [2:0]  status,
	output logic             [3:0]  position,
	output logic             [4:0]  entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE = CW'(1);

	state_t state_q, state_d;
	logic [1:0] cmd_q, cmd_d;
	logic signed [31:0] value_q, value_d;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] idx_q, idx_d;
	logic chk_q, chk_d;
	logic [CW-1:0] p_q, p_d;
	logic [CW-1:0] sh_q, sh_d;
	logic [CW-1:0] rem_q, rem_d;
	logic wr_pend_q, wr_pend_d;
	logic [AW-1:0] wr_addr_q, wr_addr_d;
	logic done_q;
	status_t status_q;
	logic [3:0] position_q;
	logic [4:0] entry_count_q;

	logic fin;
	status_t fin_status;
	logic [CW-1:0] fin_pos;

	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0] rd_data, wr_data;

	logic accept, early_fin;
	status_t early_status;
	logic is_ins;
	logic chk_ge, scan_stop, stop_hit;
	logic [CW-1:0] stop_p, ins_rem, rm_rem, sh_next_wr;

	sul_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (32)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// command decode at acceptance
	assign accept = start && (state_q == S_IDLE);
	always_comb begin
		early_fin = 1'b0;
		early_status = ST_OK;
		unique case (command)
			CMD_INSERT: begin
				if (used_q == FULL_COUNT) begin
					early_fin = 1'b1;
					early_status = ST_FULL;
				end
			end
			CMD_SEARCH, CMD_REMOVE: begin
				if (used_q == '0) begin
					early_fin = 1'b1;
					early_status = ST_EMPTY;
				end
			end
			default: begin
				early_fin = 1'b1;
				early_status = ST_OK;
			end
		endcase
	end

	// scan decision: first entry not below the value
	assign is_ins = (cmd_q == CMD_INSERT);
	assign chk_ge = chk_q && ($signed(rd_data) >= value_q);
	assign scan_stop = chk_ge || (idx_q == used_q);
	assign stop_p = chk_ge ? (idx_q - ONE) : used_q;
	assign stop_hit = chk_ge && (rd_data == value_q);
	assign ins_rem = used_q - stop_p;
	assign rm_rem = used_q - stop_p - ONE;
	assign sh_next_wr = is_ins ? (sh_q + ONE) : (sh_q - ONE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !early_fin) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_stop) begin
					state_d = S_IDLE;
					if (is_ins && !stop_hit) begin
						state_d = (ins_rem == '0) ? S_PLACE : S_SHIFT;
					end else if (cmd_q == CMD_REMOVE && stop_hit && rm_rem != '0) begin
						state_d = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				if (rem_q == '0) begin
					state_d = is_ins ? S_PLACE : S_IDLE;
				end
			end
			S_PLACE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath and memory control
	always_comb begin
		cmd_d = cmd_q;
		value_d = value_q;
		used_d = used_q;
		idx_d = idx_q;
		chk_d = chk_q;
		p_d = p_q;
		sh_d = sh_q;
		rem_d = rem_q;
		wr_pend_d = wr_pend_q;
		wr_addr_d = wr_addr_q;
		fin = 1'b0;
		fin_status = ST_OK;
		fin_pos = '0;
		rd_en = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = wr_addr_q;
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d = command;
					value_d = value;
					idx_d = '0;
					chk_d = 1'b0;
					if (early_fin) begin
						fin = 1'b1;
						fin_status = early_status;
					end
				end
			end
			S_SCAN: begin
				if (scan_stop) begin
					p_d = stop_p;
					chk_d = 1'b0;
					wr_pend_d = 1'b0;
					if (is_ins) begin
						if (stop_hit) begin
							fin = 1'b1;
							fin_status = ST_DUP;
						end else begin
							rem_d = ins_rem;
							sh_d = used_q - ONE;
						end
					end else if (!stop_hit) begin
						fin = 1'b1;
						fin_status = ST_NOTFOUND;
					end else if (cmd_q == CMD_SEARCH) begin
						fin = 1'b1;
						fin_pos = stop_p;
					end else if (rm_rem == '0) begin
						fin = 1'b1;
						fin_pos = stop_p;
						used_d = used_q - ONE;
					end else begin
						rem_d = rm_rem;
						sh_d = stop_p + ONE;
					end
				end else begin
					rd_en = 1'b1;
					rd_addr = idx_q[AW-1:0];
					idx_d = idx_q + ONE;
					chk_d = 1'b1;
				end
			end
			S_SHIFT: begin
				if (wr_pend_q) begin
					wr_en = 1'b1;
				end
				if (rem_q != '0) begin
					rd_en = 1'b1;
					rd_addr = sh_q[AW-1:0];
					wr_addr_d = sh_next_wr[AW-1:0];
					sh_d = is_ins ? (sh_q - ONE) : (sh_q + ONE);
					rem_d = rem_q - ONE;
					wr_pend_d = 1'b1;
				end else begin
					wr_pend_d = 1'b0;
					if (!is_ins) begin
						fin = 1'b1;
						fin_pos = p_q;
						used_d = used_q - ONE;
					end
				end
			end
			S_PLACE: begin
				wr_en = 1'b1;
				wr_addr = p_q[AW-1:0];
				wr_data = value_q;
				used_d = used_q + ONE;
				fin = 1'b1;
				fin_pos = p_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			chk_q <= 1'b0;
			wr_pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			chk_q <= chk_d;
			wr_pend_q <= wr_pend_d;
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		value_q <= value_d;
		idx_q <= idx_d;
		p_q <= p_d;
		sh_q <= sh_d;
		rem_q <= rem_d;
		wr_addr_q <= wr_addr_d;
		if (fin) begin
			status_q <= fin_status;
			position_q <= 4'(fin_pos);
			entry_count_q <= 5'(used_d);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign position = position_q;
	assign entry_count = entry_count_q;

	// checks
	a_used_bound : assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_COUNT)
		else $error("entry count beyond depth");

	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while still working");

	a_accept_progress : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither worked on nor answered");

	a_port_clash : assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en && rd_addr == wr_addr))
		else $error("read and write of the same entry in one cycle");

endmodule : sorted_unique_list
`default_nettype wire

// ----- sim/sorted_unique_list_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_list_test
// self-checking bench for the sorted unique list: a directed table covers
// the empty, full, duplicate and not-found cases and the value extremes,
// then random fill and drain phases over a small value pool; every result
// is checked against a typed-in result or a local predictor of the ordered store
// ----------------------------------------------------------------------------
module sorted_unique_list_test;
	import sul_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int POOL_SIZE      = 20;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 1000;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		status_t     status;
		logic [3:0]  position;
		logic [4:0]  entry_count;
	} result_t;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [31:0] val;
		bit                 typed;
		result_t            known;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic        [1:0]  command;
	logic signed [31:0] value;
	logic               done;
	logic        [2:0]  status;
	logic        [3:0]  position;
	logic        [4:0]  entry_count;

	// sideband carried with each item for rows with a typed-in result
	bit      item_typed;
	result_t item_known;

	logic signed [31:0] held_values [SUL_DEPTH];
	int                 held_count = 0;
	result_t            pending_results [$];
	int                 mismatches = 0;
	int                 idle_count = 0;

	sorted_unique_list dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.value       (value),
		.done        (done),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ordered store predictor
	task automatic apply_command(input logic [1:0] cmd, input logic signed [31:0] val,
			output result_t res);
		int slot;
		bit hit;
		slot = 0;
		while (slot < held_count && held_values[slot] < val)
			slot++;
		hit = (slot < held_count) && (held_values[slot] == val);
		res.status   = ST_OK;
		res.position = 4'd0;
		case (cmd)
			CMD_INSERT: begin
				if (held_count >= SUL_DEPTH) begin
					res.status = ST_FULL;
				end else if (hit) begin
					res.status = ST_DUP;
				end else begin
					for (int k = held_count; k > slot; k--)
						held_values[k] = held_values[k - 1];
					held_values[slot] = val;
					held_count++;
					res.position = slot[3:0];
				end
			end
			CMD_SEARCH, CMD_REMOVE: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else if (!hit) begin
					res.status = ST_NOTFOUND;
				end else begin
					res.position = slot[3:0];
					if (cmd == CMD_REMOVE) begin
						for (int k = slot; k + 1 < held_count; k++)
							held_values[k] = held_values[k + 1];
						held_count--;
					end
				end
			end
			default: ;
		endcase
		res.entry_count = held_count[4:0];
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// result checking, prediction at acceptance and the watchdog
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual status %0d position %0d count %0d",
					$time, status, position, entry_count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("position", want.position, position);
				check_field("entry_count", want.entry_count, entry_count);
			end
		end
		if (arst_n && start && !busy) begin
			apply_command(command, value, want);
			if (item_typed)
				want = item_known;
			pending_results.push_back(want);
		end
		if (arst_n && (done || (start && !busy))) begin
			idle_count = 0;
		end else if (idle_count >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_count);
			$display("sorted_unique_list_test failed");
			$finish;
		end else begin
			idle_count++;
		end
	end

	function automatic stim_row_t mk_row(input logic [1:0] cmd, input logic signed [31:0] val,
			input bit typed, input status_t st, input logic [3:0] pos, input logic [4:0] cnt);
		stim_row_t row;
		row.cmd               = cmd;
		row.val               = val;
		row.typed             = typed;
		row.known.status      = st;
		row.known.position    = pos;
		row.known.entry_count = cnt;
		return row;
	endfunction

	function automatic logic signed [31:0] pool_value();
		case ($urandom_range(0, 7))
			0:       return ($urandom_range(0, 1) == 0) ? VAL_MIN : VAL_MAX;
			1:       return ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
			2, 3, 4: return int'($urandom_range(0, 200)) - 100;
			default: return $urandom;
		endcase
	endfunction

	// called on a rising edge; returns on the edge that takes the item
	task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val,
			input bit typed, input result_t known);
		start      <= 1'b1;
		command    <= cmd;
		value      <= val;
		item_typed <= typed;
		item_known <= known;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending_results.size() != 0);
		@(posedge clk);
	endtask

	initial begin
		stim_row_t          directed_rows [$];
		logic signed [31:0] fill_values [14];
		logic signed [31:0] value_pool [POOL_SIZE];
		result_t            no_result;
		logic [1:0]         cmd;
		logic signed [31:0] val;
		bit                 fill_phase;
		bit                 pause;
		bit                 in_use;
		int                 phase_left;
		int                 burst_left;
		int                 gap;
		int                 roll;

		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_INSERT;
		value      = 32'sd0;
		item_typed = 1'b0;
		item_known = '0;
		no_result  = '0;

		fill_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd1000, -32'sd1000,
			32'sh4000_0000, 32'shc000_0000, 32'sh5555_5555, 32'shaaaa_aaaa,
			32'sd12345, -32'sd12345, 32'sd64};

		directed_rows.push_back(mk_row(CMD_SEARCH, 32'sd5, 1, ST_EMPTY, 4'd0, 5'd0));
		directed_rows.push_back(mk_row(CMD_REMOVE, 32'sd5, 1, ST_EMPTY, 4'd0, 5'd0));
		directed_rows.push_back(mk_row(CMD_UNUSED, 32'sd5, 1, ST_OK, 4'd0, 5'd0));
		directed_rows.push_back(mk_row(CMD_INSERT, VAL_MIN, 1, ST_OK, 4'd0, 5'd1));
		directed_rows.push_back(mk_row(CMD_INSERT, VAL_MAX, 1, ST_OK, 4'd1, 5'd2));
		directed_rows.push_back(mk_row(CMD_INSERT, VAL_MIN, 1, ST_DUP, 4'd0, 5'd2));
		directed_rows.push_back(mk_row(CMD_SEARCH, VAL_MAX, 1, ST_OK, 4'd1, 5'd2));
		directed_rows.push_back(mk_row(CMD_REMOVE, VAL_MIN, 1, ST_OK, 4'd0, 5'd1));
		directed_rows.push_back(mk_row(CMD_REMOVE, VAL_MIN, 1, ST_NOTFOUND, 4'd0, 5'd1));
		directed_rows.push_back(mk_row(CMD_INSERT, VAL_MIN, 1, ST_OK, 4'd0, 5'd2));
		foreach (fill_values[i])
			directed_rows.push_back(mk_row(CMD_INSERT, fill_values[i], 0, ST_OK, 4'd0, 5'd0));
		// full is reported ahead of duplicate
		directed_rows.push_back(mk_row(CMD_INSERT, 32'sd7, 1, ST_FULL, 4'd0, 5'd16));
		directed_rows.push_back(mk_row(CMD_INSERT, VAL_MAX, 1, ST_FULL, 4'd0, 5'd16));
		directed_rows.push_back(mk_row(CMD_REMOVE, VAL_MAX, 1, ST_OK, 4'd15, 5'd15));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].typed,
				directed_rows[i].known);
		start <= 1'b0;
		wait_drained();

		foreach (value_pool[i])
			value_pool[i] = pool_value();
		fill_phase = 1'b0;
		phase_left = $urandom_range(30, 80);
		burst_left = $urandom_range(1, 24);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pause = 1'b0;
			gap   = 0;
			if (phase_left == 0) begin
				pause      = !fill_phase;
				fill_phase = !fill_phase;
				phase_left = $urandom_range(30, 80);
			end
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
					: $urandom_range(1, 24);
				gap = $urandom_range(1, 16);
			end
			if (pause || gap != 0) begin
				start <= 1'b0;
				if (pause) begin
					// let the list settle, then swap out pool values not held
					wait_drained();
					foreach (value_pool[i]) begin
						in_use = 1'b0;
						for (int k = 0; k < held_count; k++)
							if (held_values[k] == value_pool[i])
								in_use = 1'b1;
						if (!in_use && $urandom_range(0, 1) == 0)
							value_pool[i] = pool_value();
					end
				end
				repeat (gap) @(posedge clk);
			end

			roll = $urandom_range(0, 99);
			if (roll < 4)
				cmd = CMD_UNUSED;
			else if (roll < (fill_phase ? 64 : 19))
				cmd = CMD_INSERT;
			else if (roll < (fill_phase ? 80 : 35))
				cmd = CMD_SEARCH;
			else
				cmd = CMD_REMOVE;
			val = ($urandom_range(0, 9) == 0) ? $urandom
				: value_pool[$urandom_range(0, POOL_SIZE - 1)];

			send_item(cmd, val, 1'b0, no_result);
			phase_left--;
			burst_left--;
		end

		start <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("sorted_unique_list_test passed");
		else
			$display("sorted_unique_list_test failed");
		$finish;
	end

endmodule : sorted_unique_list_test
`default_nettype wire
